FILE: sv/rdwu_pkg.sv
// Shared types and constants of the delay/wake unit.
// No dependencies; the datapath, controller and top level import this package.
`default_nettype none

package rdwu_pkg;

  // Default number of task slots
  localparam int MAX_TASKS_DEF = 32;

  // Wrap-aware "due" limit on (tick - wake)
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

  // Item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_DELAY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic arm;
    logic scan;
    logic load_out;
  } rdwu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_kind;
    logic scan_last;
    logic out_free;
  } rdwu_sts_t;

endpackage

`default_nettype wire

FILE: sv/rdwu_if.sv
// Valid/ready channel interfaces for input items and result items.
// No dependencies.
`default_nettype none

interface rdwu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  task_slot;
  logic [31:0] delay_ticks;
  logic [4:0]  current_priority;
  logic        same_level_ready;

  modport source (output valid, kind, task_slot, delay_ticks, current_priority,
                  same_level_ready, input ready);
  modport sink (input valid, kind, task_slot, delay_ticks, current_priority,
                same_level_ready, output ready);
endinterface

interface rdwu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] woken_mask;
  logic        yield_req;
  logic [31:0] tick_now;

  modport source (output valid, woken_mask, yield_req, tick_now, input ready);
  modport sink (input valid, woken_mask, yield_req, tick_now, output ready);
endinterface

`default_nettype wire

FILE: sv/rdwu_datapath.sv
// Datapath: tick counter, waiting flags, wake-time/priority memories,
// slot scan and output register. Depends on rdwu_pkg and rdwu_if.
`default_nettype none

module rdwu_datapath import rdwu_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  rdwu_in_if.sink         in_ch,
  rdwu_out_if.source      out_ch,
  input  wire rdwu_cmd_t  cmd,
  output rdwu_sts_t       sts
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Latched item
  logic        kind_r;
  logic [4:0]  slot_r;
  logic [31:0] delay_r;
  logic [4:0]  prio_r;

  // State
  logic [31:0]          tick_r;
  logic [MAX_TASKS-1:0] flags_r;
  logic [31:0]          wake_mem [MAX_TASKS];
  logic [4:0]           prio_mem [MAX_TASKS];

  // Scan pipeline
  logic [IDX_W-1:0] cnt_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [31:0]      rd_wake_r;
  logic [4:0]       rd_prio_r;

  // Result accumulation and output register
  logic [31:0] woken_r;
  logic        yield_r;
  logic        out_valid_r;
  logic [31:0] out_mask_r;
  logic        out_yield_r;
  logic [31:0] out_tick_r;

  logic             arm_ok;
  logic             hit;
  logic [IDX_W-1:0] slot_idx;
  logic [31:0]      wake_diff;

  assign slot_idx  = slot_r[IDX_W-1:0];
  assign arm_ok    = cmd.arm && (delay_r != 32'd0) && ({1'b0, slot_r} < 6'(MAX_TASKS));
  assign wake_diff = tick_r - rd_wake_r;
  assign hit       = rd_vld_r && flags_r[rd_idx_r] && (wake_diff < HALF_RANGE);

  // Status toward the controller
  assign sts.in_valid  = in_ch.valid;
  assign sts.in_kind   = in_ch.kind;
  assign sts.scan_last = (cnt_r == IDX_W'(MAX_TASKS - 1));
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  assign in_ch.ready = cmd.in_ready;

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r  <= in_ch.kind;
      slot_r  <= in_ch.task_slot;
      delay_r <= in_ch.delay_ticks;
      prio_r  <= in_ch.current_priority;
    end
  end

  // Write armed slots; read the scanned slot into registers
  always_ff @(posedge clk) begin
    if (arm_ok) begin
      wake_mem[slot_idx] <= tick_r + delay_r;
      prio_mem[slot_idx] <= prio_r;
    end
    if (cmd.scan) begin
      rd_wake_r <= wake_mem[cnt_r];
      rd_prio_r <= prio_mem[cnt_r];
    end
    rd_idx_r <= cnt_r;
  end

  // Counter, flags, scan control, accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= 32'd0;
      flags_r  <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      woken_r  <= 32'd0;
      yield_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.accept) begin
        cnt_r   <= '0;
        woken_r <= 32'd0;
        yield_r <= (in_ch.kind == KIND_TICK) && in_ch.same_level_ready;
        if (in_ch.kind == KIND_TICK) begin
          tick_r <= tick_r + 32'd1;
        end
      end
      if (cmd.scan) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (arm_ok) begin
        flags_r[slot_idx] <= 1'b1;
        yield_r           <= 1'b1;
      end
      // Wake a due slot
      if (hit) begin
        flags_r[rd_idx_r] <= 1'b0;
        woken_r           <= woken_r | (32'd1 << rd_idx_r);
        if (rd_prio_r < prio_r) begin
          yield_r <= 1'b1;
        end
      end
    end
  end

  // Output register: load a finished item, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mask_r  <= woken_r;
      out_yield_r <= yield_r;
      out_tick_r  <= tick_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.woken_mask = out_mask_r;
  assign out_ch.yield_req  = out_yield_r;
  assign out_ch.tick_now   = out_tick_r;

`ifndef SYNTHESIS
  a_arm_not_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.arm && cmd.scan))
    else $error("arm and scan issued together");

  a_tick_incr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && (in_ch.kind == KIND_TICK) |=> tick_r == $past(tick_r) + 32'd1)
    else $error("tick counter did not advance on a tick item");

  a_delay_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && (kind_r == KIND_DELAY) |-> woken_r == 32'd0)
    else $error("delay item reports woken slots");

  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> !flags_r[$past(rd_idx_r)])
    else $error("woken slot still waiting");
`endif

endmodule

`default_nettype wire

FILE: sv/rdwu_ctrl.sv
// Controller state machine: accept, arm or scan, then hand off to the output.
// Depends on rdwu_pkg.
`default_nettype none

module rdwu_ctrl import rdwu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rdwu_sts_t sts,
  output rdwu_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode commands from state
  always_comb begin
    cmd          = '0;
    cmd.in_ready = (state_r == ST_IDLE);
    cmd.accept   = (state_r == ST_IDLE) && sts.in_valid;
    cmd.arm      = (state_r == ST_ARM);
    cmd.scan     = (state_r == ST_SCAN);
    cmd.load_out = (state_r == ST_RESULT) && sts.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.in_valid) begin
          state_nxt = (sts.in_kind == KIND_DELAY) ? ST_ARM : ST_SCAN;
        end
      end
      ST_ARM:   state_nxt = ST_RESULT;
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rtos_delay_wake_unit.sv
// Top level of the delay/wake unit: controller plus datapath.
// Depends on rdwu_pkg, rdwu_if, rdwu_ctrl and rdwu_datapath.
//
// Usage: in_ch carries items (kind 0 = timer tick, kind 1 = delay start for
// task_slot); out_ch returns exactly one result per item, in order, with the
// woken mask, a yield request and the tick counter after the item.
// Flow: a delay item passes from acceptance through the arm and result
// states; a tick item through the scan, drain and result states, as the
// tick walks the single-port wake-time/priority memory one slot per cycle.
// One item is worked on at a time; the next one is accepted only after
// the result is loaded into the output register.
// Reset (rst_n low, synchronous) clears the tick counter, all waiting flags
// and the output register; wake-time memory needs no clearing since a slot's
// wake time is used only while its flag is set.
// If the receiver stalls, the result holds in the output register; the
// block still takes the next item, then holds that one's result internally
// until the register frees, and accepts nothing more meanwhile.
`default_nettype none

module rtos_delay_wake_unit import rdwu_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rdwu_in_if.sink    in_ch,
  rdwu_out_if.source out_ch
);

  rdwu_cmd_t cmd;
  rdwu_sts_t sts;

  rdwu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rdwu_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire
